@@ src/tdc_pkg.sv @@
// Shared types, codes and reset values for the timeline drift corrector.
`timescale 1ns / 1ps
`default_nettype none
package tdc_pkg;

   localparam int POS_W = 47;
   localparam int TIME_W = 47;
   localparam int DRIFT_W = 48;
   localparam int REV_W = 32;
   localparam int CSR_W = 16;
   localparam int CSR_IDX_W = 2;

   localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};

   localparam logic [2:0] MODE_REF = 3'd0;
   localparam logic [2:0] MODE_OBSERVE = 3'd1;
   localparam logic [2:0] MODE_CATCH_UP = 3'd2;
   localparam logic [2:0] MODE_ACTIVATE = 3'd3;
   localparam logic [2:0] MODE_DEACTIVATE = 3'd4;

   localparam logic [2:0] ST_INACTIVE = 3'd0;
   localparam logic [2:0] ST_UNKNOWN = 3'd1;
   localparam logic [2:0] ST_BUFFERING = 3'd2;
   localparam logic [2:0] ST_DESYNCED = 3'd3;
   localparam logic [2:0] ST_INSYNC = 3'd4;

   localparam logic [CSR_IDX_W-1:0] CSR_DRIFT_TOL = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SETTLE = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_COOLDOWN = 2'd2;

   localparam logic [CSR_W-1:0] DRIFT_TOL_RESET = 16'd1000;
   localparam logic [CSR_W-1:0] SETTLE_RESET = 16'd250;
   localparam logic [CSR_W-1:0] COOLDOWN_RESET = 16'd2000;

   typedef struct packed {
      logic [CSR_W-1:0] drift_tol;
      logic [CSR_W-1:0] settle;
      logic [CSR_W-1:0] cooldown;
   } csr_type;

   typedef struct packed {
      logic [2:0]        mode;
      logic              ref_playing;
      logic [POS_W-1:0]  position_ms;
      logic [REV_W-1:0]  revision;
      logic [TIME_W-1:0] now_ms;
      logic              player_paused;
      logic              player_ready;
      logic              player_buffering;
      logic              player_seeking;
   } item_type;

   typedef struct packed {
      logic               accepted;
      logic [2:0]         sync_status;
      logic [DRIFT_W-1:0] drift_ms;
      logic [POS_W-1:0]   ref_position_ms;
      logic               catch_up_available;
      logic               pause_request;
      logic               pause_target;
      logic               seek_request;
      logic [POS_W-1:0]   seek_target_ms;
   } result_type;

   typedef struct packed {
      logic               session_active;
      logic               have_reference;
      logic               ref_is_playing;
      logic [POS_W-1:0]   ref_base_position;
      logic [REV_W-1:0]   ref_revision;
      logic [TIME_W-1:0]  ref_observed_at;
      logic [POS_W-1:0]   last_ref_position;
      logic               fl_paused;
      logic               fl_ready;
      logic               fl_buffering;
      logic               fl_seeking;
      logic [POS_W-1:0]   local_position;
      logic [2:0]         status_code;
      logic [DRIFT_W-1:0] drift_value;
      logic               catch_up_flag;
      logic               seek_pending;
      logic [POS_W-1:0]   seek_target;
      logic [TIME_W-1:0]  seek_requested_at;
      logic               pause_pending;
      logic               pause_wanted;
      logic [TIME_W-1:0]  pause_requested_at;
   } state_type;

   localparam state_type STATE_RESET = '{
      session_active: 1'b0,
      have_reference: 1'b0,
      ref_is_playing: 1'b0,
      ref_base_position: '0,
      ref_revision: '0,
      ref_observed_at: '0,
      last_ref_position: '0,
      fl_paused: 1'b1,
      fl_ready: 1'b0,
      fl_buffering: 1'b0,
      fl_seeking: 1'b0,
      local_position: '0,
      status_code: ST_UNKNOWN,
      drift_value: '0,
      catch_up_flag: 1'b0,
      seek_pending: 1'b0,
      seek_target: '0,
      seek_requested_at: '0,
      pause_pending: 1'b0,
      pause_wanted: 1'b1,
      pause_requested_at: '0
   };

endpackage
`default_nettype wire

@@ src/tdc_csr.sv @@
// Configuration registers of the timeline drift corrector.
`timescale 1ns / 1ps
`default_nettype none
module tdc_csr (
   input  wire                               clock,
   input  wire                               reset,
   input  wire                               csr_valid,
   output logic                              csr_ready,
   input  wire  [tdc_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire  [tdc_pkg::CSR_W-1:0]         csr_data,
   output tdc_pkg::csr_type                  csr_cfg
);
   import tdc_pkg::*;

   csr_type cfg_ff;
   csr_type cfg_in;

   assign csr_ready = 1'b1;
   assign csr_cfg = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_DRIFT_TOL: cfg_in.drift_tol = csr_data;
            CSR_SETTLE: cfg_in.settle = csr_data;
            CSR_COOLDOWN: cfg_in.cooldown = csr_data;
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.drift_tol <= DRIFT_TOL_RESET;
         cfg_ff.settle <= SETTLE_RESET;
         cfg_ff.cooldown <= COOLDOWN_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule
`default_nettype wire

@@ src/tdc_step.sv @@
// Next-state and result logic for one event of the timeline drift corrector.
`timescale 1ns / 1ps
`default_nettype none
module tdc_step (
   input  tdc_pkg::state_type  state_cur,
   input  tdc_pkg::item_type   item,
   input  tdc_pkg::csr_type    cfg,
   output tdc_pkg::state_type  state_nxt,
   output tdc_pkg::result_type result
);
   import tdc_pkg::*;

   logic is_ref, is_obs, is_catch, is_act, is_deact;
   logic paused_e, buffering_e, seeking_e, playing_e;
   logic ref_ok, newer, catch_ok, accepted, recon, force_fix;
   logic [TIME_W:0] span;
   logic [POS_W:0] ext_sum;
   logic [POS_W-1:0] ext_pos, refpos, local_sel;
   logic [DRIFT_W-1:0] drift, absd;
   logic gt_tol, gt_settle, thr_hit;
   logic [POS_W:0] settle_diff, settle_abs;
   logic settled;
   logic [TIME_W:0] pause_gap, seek_gap;
   logic seek_pend_e, pause_pend_e, due_pause, due_seek;
   logic want_paused, mismatch, do_pause, do_seek, out_of_sync;

   assign is_ref = (item.mode == MODE_REF);
   assign is_obs = (item.mode == MODE_OBSERVE);
   assign is_catch = (item.mode == MODE_CATCH_UP);
   assign is_act = (item.mode == MODE_ACTIVATE);
   assign is_deact = (item.mode == MODE_DEACTIVATE);

   assign paused_e = is_obs ? item.player_paused : state_cur.fl_paused;
   assign buffering_e = is_obs ? item.player_buffering : state_cur.fl_buffering;
   assign seeking_e = is_obs ? item.player_seeking : state_cur.fl_seeking;
   assign playing_e = is_ref ? item.ref_playing : state_cur.ref_is_playing;

   assign ref_ok = state_cur.session_active
                   && !(state_cur.have_reference && item.revision < state_cur.ref_revision);
   assign newer = !state_cur.have_reference || item.revision > state_cur.ref_revision;
   assign catch_ok = state_cur.session_active && state_cur.have_reference
                     && state_cur.fl_ready && !state_cur.fl_buffering
                     && !state_cur.fl_seeking;
   assign accepted = (is_ref && ref_ok) || (is_obs && state_cur.session_active)
                     || (is_catch && catch_ok) || is_act || is_deact;
   assign recon = (is_ref && ref_ok && state_cur.fl_ready)
                  || (is_obs && state_cur.session_active && state_cur.have_reference
                      && item.player_ready)
                  || (is_catch && catch_ok);
   assign force_fix = is_catch || (is_obs && state_cur.fl_buffering);

   // The reference position moves on with elapsed time while it plays.
   assign span = {1'b0, item.now_ms} - {1'b0, state_cur.ref_observed_at};
   assign ext_sum = {1'b0, state_cur.ref_base_position}
                    + (span[TIME_W] ? '0 : {1'b0, span[TIME_W-1:0]});
   assign ext_pos = !state_cur.ref_is_playing ? state_cur.ref_base_position
                    : (ext_sum[POS_W] ? POS_MAX : ext_sum[POS_W-1:0]);
   assign refpos = is_ref ? item.position_ms : ext_pos;
   assign local_sel = is_obs ? item.position_ms : state_cur.local_position;

   assign drift = {1'b0, local_sel} - {1'b0, refpos};
   assign absd = drift[DRIFT_W-1] ? (~drift + 1'b1) : drift;
   assign gt_tol = absd > {{(DRIFT_W-CSR_W){1'b0}}, cfg.drift_tol};
   assign gt_settle = absd > {{(DRIFT_W-CSR_W){1'b0}}, cfg.settle};
   assign thr_hit = force_fix ? gt_settle : gt_tol;

   assign settle_diff = {1'b0, item.position_ms} - {1'b0, state_cur.seek_target};
   assign settle_abs = settle_diff[POS_W] ? (~settle_diff + 1'b1) : settle_diff;
   assign settled = settle_abs <= {{(POS_W+1-CSR_W){1'b0}}, cfg.settle};

   always_comb begin
      if (is_ref && newer) begin
         seek_pend_e = 1'b0;
         pause_pend_e = 1'b0;
      end else if (is_obs) begin
         seek_pend_e = state_cur.seek_pending && !settled;
         pause_pend_e = state_cur.pause_pending
                        && (item.player_paused != state_cur.pause_wanted);
      end else begin
         seek_pend_e = state_cur.seek_pending;
         pause_pend_e = state_cur.pause_pending;
      end
   end

   // A request start that lies in the future gives a negative gap and is not yet due.
   assign pause_gap = {1'b0, item.now_ms} - {1'b0, state_cur.pause_requested_at};
   assign seek_gap = {1'b0, item.now_ms} - {1'b0, state_cur.seek_requested_at};
   assign due_pause = !pause_pend_e
                      || (!pause_gap[TIME_W]
                          && pause_gap[TIME_W-1:0] >= {{(TIME_W-CSR_W){1'b0}}, cfg.cooldown});
   assign due_seek = !seek_pend_e
                     || (!seek_gap[TIME_W]
                         && seek_gap[TIME_W-1:0] >= {{(TIME_W-CSR_W){1'b0}}, cfg.cooldown});

   assign want_paused = !playing_e;
   assign mismatch = paused_e != want_paused;
   assign do_pause = recon && !buffering_e && mismatch && (force_fix || due_pause);
   assign do_seek = recon && !buffering_e && !seeking_e && thr_hit
                    && (force_fix || due_seek);
   assign out_of_sync = mismatch || gt_tol || pause_pend_e || do_pause
                        || seek_pend_e || do_seek;

   always_comb begin
      state_nxt = state_cur;
      if (is_act || is_deact) begin
         state_nxt = STATE_RESET;
         state_nxt.session_active = is_act;
      end else if (accepted) begin
         if (is_ref) begin
            state_nxt.ref_is_playing = item.ref_playing;
            state_nxt.ref_base_position = item.position_ms;
            state_nxt.ref_revision = item.revision;
            state_nxt.ref_observed_at = item.now_ms;
            state_nxt.last_ref_position = item.position_ms;
            state_nxt.have_reference = 1'b1;
            if (newer) begin
               state_nxt.pause_wanted = 1'b1;
            end
         end
         if (is_obs) begin
            state_nxt.local_position = item.position_ms;
            state_nxt.fl_paused = item.player_paused;
            state_nxt.fl_ready = item.player_ready;
            state_nxt.fl_buffering = item.player_buffering;
            state_nxt.fl_seeking = item.player_seeking;
            if (!state_cur.have_reference) begin
               state_nxt.status_code = ST_UNKNOWN;
               state_nxt.catch_up_flag = 1'b0;
               state_nxt.drift_value = '0;
            end else if (!item.player_ready) begin
               state_nxt.status_code = ST_UNKNOWN;
               state_nxt.catch_up_flag = 1'b0;
            end
         end
         state_nxt.seek_pending = seek_pend_e;
         state_nxt.pause_pending = pause_pend_e;
         if (recon) begin
            state_nxt.last_ref_position = refpos;
            state_nxt.drift_value = drift;
            if (buffering_e) begin
               state_nxt.status_code = ST_BUFFERING;
               state_nxt.catch_up_flag = 1'b0;
            end else begin
               if (do_pause) begin
                  state_nxt.pause_pending = 1'b1;
                  state_nxt.pause_wanted = want_paused;
                  state_nxt.pause_requested_at = item.now_ms;
               end
               if (do_seek) begin
                  state_nxt.seek_pending = 1'b1;
                  state_nxt.seek_target = refpos;
                  state_nxt.seek_requested_at = item.now_ms;
               end
               state_nxt.status_code = out_of_sync ? ST_DESYNCED : ST_INSYNC;
               state_nxt.catch_up_flag = out_of_sync && !seeking_e;
            end
         end
      end
   end

   always_comb begin
      result.accepted = accepted;
      result.sync_status = state_nxt.session_active ? state_nxt.status_code : ST_INACTIVE;
      result.drift_ms = state_nxt.session_active ? state_nxt.drift_value : '0;
      result.ref_position_ms = state_nxt.have_reference ? state_nxt.last_ref_position : '0;
      result.catch_up_available = state_nxt.catch_up_flag;
      result.pause_request = do_pause;
      result.pause_target = do_pause && want_paused;
      result.seek_request = do_seek;
      result.seek_target_ms = do_seek ? refpos : '0;
   end

endmodule
`default_nettype wire

@@ src/timeline_drift_corrector.sv @@
// Top level of the timeline drift corrector: beat registers, state and result register.
// Usage:
// Events enter on the req_ channel; a beat is taken when req_valid is high and
// req_stall is low. Every event gives exactly one result beat on the rsp_
// channel, taken when rsp_valid is high and rsp_stall is low.
// An event is captured in an input register, evaluated against the session
// state and written to the result register, from which its result beat is
// offered. One event is taken per cycle while the receiver does not stall;
// the figure is set by the single evaluation stage that updates the state.
// When the receiver stalls, the result register holds its beat and the input
// register keeps one more event; after that req_stall rises.
// The csr_ channel writes the drift tolerance, settle window and cooldown
// (index 0 to 2, other indexes ignored) and is always ready; write it only
// while no event is in flight.
// Reset is synchronous: the session is inactive, no reference is known and
// the registers return to 1000, 250 and 2000 ms.
`timescale 1ns / 1ps
`default_nettype none
module timeline_drift_corrector (
   input  wire                                   clock,
   input  wire                                   reset,
   input  wire                                   req_valid,
   output logic                                  req_stall,
   input  wire  [2:0]                            req_mode,
   input  wire                                   req_ref_playing,
   input  wire  [tdc_pkg::POS_W-1:0]             req_position_ms,
   input  wire  [tdc_pkg::REV_W-1:0]             req_revision,
   input  wire  [tdc_pkg::TIME_W-1:0]            req_now_ms,
   input  wire                                   req_player_paused,
   input  wire                                   req_player_ready,
   input  wire                                   req_player_buffering,
   input  wire                                   req_player_seeking,
   output logic                                  rsp_valid,
   input  wire                                   rsp_stall,
   output logic                                  rsp_accepted,
   output logic [2:0]                            rsp_sync_status,
   output logic signed [tdc_pkg::DRIFT_W-1:0]    rsp_drift_ms,
   output logic [tdc_pkg::POS_W-1:0]             rsp_ref_position_ms,
   output logic                                  rsp_catch_up_available,
   output logic                                  rsp_pause_request,
   output logic                                  rsp_pause_target,
   output logic                                  rsp_seek_request,
   output logic [tdc_pkg::POS_W-1:0]             rsp_seek_target_ms,
   input  wire                                   csr_valid,
   output logic                                  csr_ready,
   input  wire  [tdc_pkg::CSR_IDX_W-1:0]         csr_index,
   input  wire  [tdc_pkg::CSR_W-1:0]             csr_data
);
   import tdc_pkg::*;

   csr_type cfg;
   item_type item_ff, item_in;
   logic item_valid_ff, item_valid_in;
   state_type state_ff, state_in;
   result_type res_ff, res_in;
   logic res_valid_ff, res_valid_in;
   logic out_free, advance, take_req;

   tdc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .csr_cfg   (cfg)
   );

   tdc_step u_step (
      .state_cur (state_ff),
      .item      (item_ff),
      .cfg       (cfg),
      .state_nxt (state_in),
      .result    (res_in)
   );

   assign out_free = !res_valid_ff || !rsp_stall;
   assign advance = item_valid_ff && out_free;
   assign req_stall = item_valid_ff && !out_free;
   assign take_req = req_valid && !req_stall;

   assign item_valid_in = take_req || (item_valid_ff && !advance);
   assign res_valid_in = advance || (res_valid_ff && rsp_stall);

   always_comb begin
      item_in = item_ff;
      if (take_req) begin
         item_in.mode = req_mode;
         item_in.ref_playing = req_ref_playing;
         item_in.position_ms = req_position_ms;
         item_in.revision = req_revision;
         item_in.now_ms = req_now_ms;
         item_in.player_paused = req_player_paused;
         item_in.player_ready = req_player_ready;
         item_in.player_buffering = req_player_buffering;
         item_in.player_seeking = req_player_seeking;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         res_valid_ff <= 1'b0;
         state_ff <= STATE_RESET;
      end else begin
         item_valid_ff <= item_valid_in;
         res_valid_ff <= res_valid_in;
         if (advance) begin
            state_ff <= state_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
      if (advance) begin
         res_ff <= res_in;
      end
   end

   assign rsp_valid = res_valid_ff;
   assign rsp_accepted = res_ff.accepted;
   assign rsp_sync_status = res_ff.sync_status;
   assign rsp_drift_ms = res_ff.drift_ms;
   assign rsp_ref_position_ms = res_ff.ref_position_ms;
   assign rsp_catch_up_available = res_ff.catch_up_available;
   assign rsp_pause_request = res_ff.pause_request;
   assign rsp_pause_target = res_ff.pause_target;
   assign rsp_seek_request = res_ff.seek_request;
   assign rsp_seek_target_ms = res_ff.seek_target_ms;

endmodule
`default_nettype wire

@@ tb/sv/timeline_drift_corrector_tb.sv @@
// Self-checking testbench for the timeline drift corrector: directed table, then random sessions.
`timescale 1ns / 1ps
module timeline_drift_corrector_tb;
   import tdc_pkg::*;

   localparam logic [2:0] MODE_UNUSED_LO = 3'd5;
   localparam logic [2:0] MODE_UNUSED_HI = 3'd7;
   localparam longint POS_LIMIT = POS_MAX;

   typedef struct {
      item_type   ev;
      bit         typed;
      result_type want;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                      req_valid = 1'b0;
   logic                      req_stall;
   logic [2:0]                req_mode = MODE_REF;
   logic                      req_ref_playing = 1'b0;
   logic [POS_W-1:0]          req_position_ms = '0;
   logic [REV_W-1:0]          req_revision = '0;
   logic [TIME_W-1:0]         req_now_ms = '0;
   logic                      req_player_paused = 1'b0;
   logic                      req_player_ready = 1'b0;
   logic                      req_player_buffering = 1'b0;
   logic                      req_player_seeking = 1'b0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   logic                      rsp_accepted;
   logic [2:0]                rsp_sync_status;
   logic signed [DRIFT_W-1:0] rsp_drift_ms;
   logic [POS_W-1:0]          rsp_ref_position_ms;
   logic                      rsp_catch_up_available;
   logic                      rsp_pause_request;
   logic                      rsp_pause_target;
   logic                      rsp_seek_request;
   logic [POS_W-1:0]          rsp_seek_target_ms;
   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   logic [CSR_IDX_W-1:0]      csr_index = CSR_DRIFT_TOL;
   logic [CSR_W-1:0]          csr_data = '0;

   timeline_drift_corrector u_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_mode(req_mode),
      .req_ref_playing(req_ref_playing),
      .req_position_ms(req_position_ms),
      .req_revision(req_revision),
      .req_now_ms(req_now_ms),
      .req_player_paused(req_player_paused),
      .req_player_ready(req_player_ready),
      .req_player_buffering(req_player_buffering),
      .req_player_seeking(req_player_seeking),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_accepted(rsp_accepted),
      .rsp_sync_status(rsp_sync_status),
      .rsp_drift_ms(rsp_drift_ms),
      .rsp_ref_position_ms(rsp_ref_position_ms),
      .rsp_catch_up_available(rsp_catch_up_available),
      .rsp_pause_request(rsp_pause_request),
      .rsp_pause_target(rsp_pause_target),
      .rsp_seek_request(rsp_seek_request),
      .rsp_seek_target_ms(rsp_seek_target_ms),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   logic [CSR_W-1:0] tol_cfg = DRIFT_TOL_RESET;
   logic [CSR_W-1:0] settle_cfg = SETTLE_RESET;
   logic [CSR_W-1:0] cooldown_cfg = COOLDOWN_RESET;

   bit               sess_on, ref_known, ref_running;
   logic [POS_W-1:0] ref_base, last_ref, pl_pos, seek_tgt;
   logic [REV_W-1:0] ref_rev;
   longint           ref_seen_at, seek_at, pause_at, drift_val;
   bit               pl_paused, pl_ready, pl_buffering, pl_seeking;
   logic [2:0]       status;
   bit               catch_up, seek_pend, pause_pend, pause_want;
   bit               out_pause, out_pause_tgt, out_seek;
   logic [POS_W-1:0] out_seek_tgt;

   result_type pending_sync_results[$];
   int         mismatch_count = 0;
   int         sender_idle_pct = 0;
   int         recv_stall_pct = 0;
   int         holds_asked = 0;
   int         holds_done = 0;
   int         hold_left = 0;
   longint     gen_now = 0;

   function automatic void clear_corrections();
      seek_pend = 1'b0;
      seek_tgt = '0;
      seek_at = -1;
      pause_pend = 1'b0;
      pause_want = 1'b1;
      pause_at = -1;
   endfunction

   function automatic void clear_session();
      sess_on = 1'b0;
      ref_known = 1'b0;
      ref_running = 1'b0;
      ref_base = '0;
      ref_rev = '0;
      ref_seen_at = -1;
      last_ref = '0;
      pl_ready = 1'b0;
      pl_paused = 1'b1;
      pl_buffering = 1'b0;
      pl_seeking = 1'b0;
      pl_pos = '0;
      status = ST_UNKNOWN;
      drift_val = 0;
      catch_up = 1'b0;
      clear_corrections();
   endfunction

   function automatic longint ref_pos_at(longint now);
      longint elapsed, sum;
      if (!ref_known) return 0;
      if (!ref_running || ref_seen_at < 0) return longint'(ref_base);
      elapsed = now - ref_seen_at;
      if (elapsed < 0) elapsed = 0;
      sum = longint'(ref_base) + elapsed;
      return (sum > POS_LIMIT) ? POS_LIMIT : sum;
   endfunction

   function automatic bit cooldown_over(bit pending, longint at, longint now);
      return !pending || at < 0 || (now - at) >= longint'(cooldown_cfg);
   endfunction

   function automatic void reconcile_pass(longint now, bit forced);
      longint refpos, absd, thr;
      bit want_p, mismatch, oos;
      if (!sess_on || !ref_known || !pl_ready) return;
      refpos = ref_pos_at(now);
      last_ref = POS_W'(refpos);
      drift_val = longint'(pl_pos) - refpos;
      if (pl_buffering) begin
         status = ST_BUFFERING;
         catch_up = 1'b0;
         return;
      end
      want_p = !ref_running;
      mismatch = (pl_paused != want_p);
      absd = (drift_val < 0) ? -drift_val : drift_val;
      if (mismatch && (forced || cooldown_over(pause_pend, pause_at, now))) begin
         pause_pend = 1'b1;
         pause_want = want_p;
         pause_at = now;
         out_pause = 1'b1;
         out_pause_tgt = want_p;
      end
      thr = forced ? longint'(settle_cfg) : longint'(tol_cfg);
      if (!pl_seeking && absd > thr && (forced || cooldown_over(seek_pend, seek_at, now))) begin
         seek_pend = 1'b1;
         seek_tgt = POS_W'(refpos);
         seek_at = now;
         out_seek = 1'b1;
         out_seek_tgt = POS_W'(refpos);
      end
      oos = mismatch || absd > longint'(tol_cfg) || pause_pend || seek_pend;
      status = oos ? ST_DESYNCED : ST_INSYNC;
      catch_up = oos && !pl_seeking;
   endfunction

   function automatic result_type predict_sync_step(item_type ev);
      result_type r;
      longint now, d;
      bit acc, newer, was_buf;
      now = longint'(ev.now_ms);
      acc = 1'b0;
      out_pause = 1'b0;
      out_pause_tgt = 1'b0;
      out_seek = 1'b0;
      out_seek_tgt = '0;
      case (ev.mode)
         MODE_REF: begin
            if (sess_on && !(ref_known && ev.revision < ref_rev)) begin
               newer = !ref_known || ev.revision > ref_rev;
               ref_running = ev.ref_playing;
               ref_base = ev.position_ms;
               ref_rev = ev.revision;
               ref_seen_at = now;
               last_ref = ev.position_ms;
               ref_known = 1'b1;
               if (newer) clear_corrections();
               reconcile_pass(now, 1'b0);
               acc = 1'b1;
            end
         end
         MODE_OBSERVE: begin
            if (sess_on) begin
               was_buf = pl_buffering;
               pl_pos = ev.position_ms;
               pl_paused = ev.player_paused;
               pl_ready = ev.player_ready;
               pl_buffering = ev.player_buffering;
               pl_seeking = ev.player_seeking;
               d = longint'(pl_pos) - longint'(seek_tgt);
               if (d < 0) d = -d;
               if (seek_pend && d <= longint'(settle_cfg)) begin
                  seek_pend = 1'b0;
                  seek_at = -1;
               end
               if (pause_pend && pl_paused == pause_want) begin
                  pause_pend = 1'b0;
                  pause_at = -1;
               end
               if (!ref_known) begin
                  status = ST_UNKNOWN;
                  catch_up = 1'b0;
                  drift_val = 0;
               end else if (!pl_ready) begin
                  status = ST_UNKNOWN;
                  catch_up = 1'b0;
               end else if (pl_buffering) begin
                  last_ref = POS_W'(ref_pos_at(now));
                  drift_val = longint'(pl_pos) - ref_pos_at(now);
                  status = ST_BUFFERING;
                  catch_up = 1'b0;
               end else begin
                  reconcile_pass(now, was_buf);
               end
               acc = 1'b1;
            end
         end
         MODE_CATCH_UP: begin
            if (sess_on && ref_known && pl_ready && !pl_buffering && !pl_seeking) begin
               reconcile_pass(now, 1'b1);
               acc = 1'b1;
            end
         end
         MODE_ACTIVATE: begin
            clear_session();
            sess_on = 1'b1;
            acc = 1'b1;
         end
         MODE_DEACTIVATE: begin
            clear_session();
            acc = 1'b1;
         end
         default: ;
      endcase
      r.accepted = acc;
      r.sync_status = sess_on ? status : ST_INACTIVE;
      r.drift_ms = sess_on ? drift_val[DRIFT_W-1:0] : '0;
      r.ref_position_ms = ref_known ? last_ref : '0;
      r.catch_up_available = catch_up;
      r.pause_request = out_pause;
      r.pause_target = out_pause_tgt;
      r.seek_request = out_seek;
      r.seek_target_ms = out_seek_tgt;
      return r;
   endfunction

   function automatic item_type mk_item(logic [2:0] mode, bit playing, logic [POS_W-1:0] pos,
                                        logic [REV_W-1:0] rev, logic [TIME_W-1:0] now,
                                        bit paused, bit ready, bit buffering, bit seeking);
      item_type ev;
      ev.mode = mode;
      ev.ref_playing = playing;
      ev.position_ms = pos;
      ev.revision = rev;
      ev.now_ms = now;
      ev.player_paused = paused;
      ev.player_ready = ready;
      ev.player_buffering = buffering;
      ev.player_seeking = seeking;
      return ev;
   endfunction

   function automatic result_type mk_res(bit acc, logic [2:0] st, longint drift,
                                         logic [POS_W-1:0] refpos, bit cu, bit pr, bit pt,
                                         bit sr, logic [POS_W-1:0] stgt);
      result_type r;
      r.accepted = acc;
      r.sync_status = st;
      r.drift_ms = drift[DRIFT_W-1:0];
      r.ref_position_ms = refpos;
      r.catch_up_available = cu;
      r.pause_request = pr;
      r.pause_target = pt;
      r.seek_request = sr;
      r.seek_target_ms = stgt;
      return r;
   endfunction

   function automatic logic [POS_W-1:0] rand47();
      logic [63:0] w;
      w = {$urandom(), $urandom()};
      return w[POS_W-1:0];
   endfunction

   function automatic longint spread(longint lim);
      return longint'($urandom_range(int'(2 * lim))) - lim;
   endfunction

   function automatic logic [POS_W-1:0] clamp_pos(longint p);
      if (p < 0) return '0;
      if (p > POS_LIMIT) return POS_MAX;
      return p[POS_W-1:0];
   endfunction

   function automatic item_type next_event();
      item_type ev;
      int roll, pick;
      longint base, pos;
      pick = $urandom_range(99);
      if (pick < 4) begin
         gen_now = longint'(rand47());
      end else if (pick < 9) begin
         gen_now = gen_now - longint'($urandom_range(5000));
         if (gen_now < 0) gen_now = 0;
      end else begin
         gen_now = gen_now + longint'($urandom_range(2500));
         if (gen_now > POS_LIMIT) gen_now = 0;
      end
      ev.now_ms = gen_now[TIME_W-1:0];
      ev.ref_playing = 1'($urandom_range(1));
      ev.position_ms = rand47();
      ev.revision = $urandom();
      ev.player_paused = 1'($urandom_range(1));
      ev.player_ready = 1'($urandom_range(1));
      ev.player_buffering = 1'($urandom_range(1));
      ev.player_seeking = 1'($urandom_range(1));
      roll = $urandom_range(99);
      if (!sess_on && $urandom_range(3) != 0) roll = 0;
      if (roll < 3) begin
         ev.mode = MODE_ACTIVATE;
      end else if (roll < 6) begin
         ev.mode = MODE_DEACTIVATE;
      end else if (roll < 9) begin
         ev.mode = MODE_UNUSED_LO + 3'($urandom_range(2));
      end else if (roll < 35) begin
         ev.mode = MODE_REF;
         pick = $urandom_range(99);
         if (ref_known && pick < 10) ev.revision = ref_rev - 32'd1;
         else if (ref_known && pick < 50) ev.revision = ref_rev;
         else if (ref_known && pick < 95) ev.revision = ref_rev + 32'($urandom_range(1, 3));
         else if (!ref_known && pick < 90) ev.revision = 32'($urandom_range(100));
         pick = $urandom_range(99);
         if (pick < 5) begin
            ev.position_ms = POS_MAX - POS_W'($urandom_range(5000));
         end else if (pick >= 10) begin
            pos = ref_pos_at(gen_now) + spread(3000);
            ev.position_ms = clamp_pos(pos);
         end
      end else if (roll < 85) begin
         ev.mode = MODE_OBSERVE;
         base = ref_pos_at(gen_now);
         pick = $urandom_range(99);
         if (pick < 25) pos = base + spread(500);
         else if (pick < 55) pos = base + spread(longint'(tol_cfg) + 300);
         else if (pick < 75) pos = longint'(seek_tgt) + spread(longint'(settle_cfg) + 50);
         else if (pick < 96) pos = base + spread(200000);
         else pos = longint'(rand47());
         ev.position_ms = clamp_pos(pos);
         ev.player_paused = ($urandom_range(99) < 75) ? !ref_running : 1'($urandom_range(1));
         ev.player_ready = ($urandom_range(99) < 90);
         ev.player_buffering = ($urandom_range(99) < 12);
         ev.player_seeking = ($urandom_range(99) < 15);
      end else begin
         ev.mode = MODE_CATCH_UP;
      end
      return ev;
   endfunction

   task automatic report_failure(string what);
      mismatch_count++;
      $display("%0t mismatch: %s", $time, what);
   endtask

   task automatic compare_field(string name, logic [63:0] got, logic [63:0] want);
      if (got !== want) report_failure($sformatf("%s got %0h want %0h", name, got, want));
   endtask

   always @(posedge clock) begin : rsp_check
      result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_sync_results.size() == 0) begin
            report_failure("result beat with nothing expected");
         end else begin
            want = pending_sync_results.pop_front();
            compare_field("accepted", rsp_accepted, want.accepted);
            compare_field("sync_status", rsp_sync_status, want.sync_status);
            compare_field("drift_ms", $unsigned(rsp_drift_ms), want.drift_ms);
            compare_field("ref_position_ms", rsp_ref_position_ms, want.ref_position_ms);
            compare_field("catch_up_available", rsp_catch_up_available,
                          want.catch_up_available);
            compare_field("pause_request", rsp_pause_request, want.pause_request);
            compare_field("pause_target", rsp_pause_target, want.pause_target);
            compare_field("seek_request", rsp_seek_request, want.seek_request);
            compare_field("seek_target_ms", rsp_seek_target_ms, want.seek_target_ms);
         end
      end
   end

   always @(posedge clock) begin
      if (holds_done != holds_asked) begin
         hold_left <= 60;
         holds_done <= holds_done + 1;
         rsp_stall <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_stall_pct);
      end
   end

   task automatic send_event(item_type ev, bit typed, result_type typed_want);
      result_type predicted;
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_mode <= ev.mode;
      req_ref_playing <= ev.ref_playing;
      req_position_ms <= ev.position_ms;
      req_revision <= ev.revision;
      req_now_ms <= ev.now_ms;
      req_player_paused <= ev.player_paused;
      req_player_ready <= ev.player_ready;
      req_player_buffering <= ev.player_buffering;
      req_player_seeking <= ev.player_seeking;
      do @(posedge clock); while (req_stall);
      predicted = predict_sync_step(ev);
      pending_sync_results.push_back(typed ? typed_want : predicted);
   endtask

   task automatic wait_for_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_sync_results.size() != 0);
   endtask

   task automatic apply_config(logic [CSR_W-1:0] tol, logic [CSR_W-1:0] settle,
                               logic [CSR_W-1:0] cool);
      logic [CSR_IDX_W-1:0] idx [3];
      logic [CSR_W-1:0]     val [3];
      idx = '{CSR_DRIFT_TOL, CSR_SETTLE, CSR_COOLDOWN};
      val = '{tol, settle, cool};
      for (int i = 0; i < 3; i++) begin
         csr_valid <= 1'b1;
         csr_index <= idx[i];
         csr_data <= val[i];
         do @(posedge clock); while (!csr_ready);
      end
      csr_valid <= 1'b0;
      tol_cfg = tol;
      settle_cfg = settle;
      cooldown_cfg = cool;
   endtask

   task automatic run_phase(int count, int idle_pct, int stall_pct, bit pressure,
                            logic [CSR_W-1:0] tol, logic [CSR_W-1:0] settle,
                            logic [CSR_W-1:0] cool);
      item_type ev;
      int done;
      bit held, paused_once;
      done = 0;
      held = 1'b0;
      paused_once = 1'b0;
      wait_for_results();
      repeat (4) @(posedge clock);
      apply_config(tol, settle, cool);
      sender_idle_pct = idle_pct;
      recv_stall_pct = stall_pct;
      while (done < count) begin
         if (pressure && !held && done >= count / 4) begin
            holds_asked++;
            held = 1'b1;
         end
         if (pressure && !paused_once && done >= count / 2) begin
            wait_for_results();
            paused_once = 1'b1;
         end
         ev = next_event();
         send_event(ev, 1'b0, '0);
         if (ev.mode <= MODE_DEACTIVATE) done++;
      end
   endtask

   initial begin
      stim_row_type rows[$];
      int wait_cycles;
      clear_session();
      rows.push_back('{mk_item(MODE_REF, 1, 10000, 5, 1000, 0, 1, 0, 0), 1'b1,
                       mk_res(0, ST_INACTIVE, 0, 0, 0, 0, 0, 0, 0)});
      rows.push_back('{mk_item(MODE_UNUSED_HI, 1, 7, 1, 1000, 1, 1, 1, 1), 1'b1,
                       mk_res(0, ST_INACTIVE, 0, 0, 0, 0, 0, 0, 0)});
      rows.push_back('{mk_item(MODE_CATCH_UP, 0, 0, 0, 1000, 0, 0, 0, 0), 1'b1,
                       mk_res(0, ST_INACTIVE, 0, 0, 0, 0, 0, 0, 0)});
      rows.push_back('{mk_item(MODE_DEACTIVATE, 0, 0, 0, 1000, 0, 0, 0, 0), 1'b1,
                       mk_res(1, ST_INACTIVE, 0, 0, 0, 0, 0, 0, 0)});
      rows.push_back('{mk_item(MODE_ACTIVATE, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1,
                       mk_res(1, ST_UNKNOWN, 0, 0, 0, 0, 0, 0, 0)});
      rows.push_back('{mk_item(MODE_OBSERVE, 0, 5000, 0, 500, 0, 1, 0, 0), 1'b1,
                       mk_res(1, ST_UNKNOWN, 0, 0, 0, 0, 0, 0, 0)});
      rows.push_back('{mk_item(MODE_CATCH_UP, 0, 0, 0, 600, 0, 0, 0, 0), 1'b1,
                       mk_res(0, ST_UNKNOWN, 0, 0, 0, 0, 0, 0, 0)});
      rows.push_back('{mk_item(MODE_REF, 1, 10000, 5, 1000, 0, 0, 0, 0), 1'b1,
                       mk_res(1, ST_DESYNCED, -5000, 10000, 1, 0, 0, 1, 10000)});
      rows.push_back('{mk_item(MODE_REF, 1, 900, 4, 1100, 0, 0, 0, 0), 1'b1,
                       mk_res(0, ST_DESYNCED, -5000, 10000, 1, 0, 0, 0, 0)});
      rows.push_back('{mk_item(MODE_OBSERVE, 0, 11200, 0, 1500, 0, 1, 0, 0), 1'b0, '0});
      rows.push_back('{mk_item(MODE_CATCH_UP, 0, 0, 0, 1600, 0, 0, 0, 0), 1'b0, '0});
      rows.push_back('{mk_item(MODE_OBSERVE, 0, 11650, 0, 1700, 0, 0, 0, 0), 1'b0, '0});
      rows.push_back('{mk_item(MODE_REF, 1, 20000, 6, 2000, 0, 0, 0, 0), 1'b0, '0});
      rows.push_back('{mk_item(MODE_OBSERVE, 0, 20100, 0, 2100, 0, 1, 1, 0), 1'b0, '0});
      rows.push_back('{mk_item(MODE_OBSERVE, 0, 20150, 0, 2200, 0, 1, 0, 0), 1'b0, '0});
      rows.push_back('{mk_item(MODE_OBSERVE, 0, 20300, 0, 2300, 0, 1, 0, 1), 1'b0, '0});
      rows.push_back('{mk_item(MODE_REF, 0, 20300, 6, 2400, 0, 0, 0, 0), 1'b0, '0});
      rows.push_back('{mk_item(MODE_OBSERVE, 0, 20300, 0, 1000, 0, 1, 0, 0), 1'b0, '0});
      rows.push_back('{mk_item(MODE_REF, 1, POS_MAX - 47'd100, 32'hFFFF_FFFF, 3000,
                               0, 0, 0, 0), 1'b0, '0});
      rows.push_back('{mk_item(MODE_OBSERVE, 0, POS_MAX, 0, 9000, 0, 1, 0, 0), 1'b0, '0});
      rows.push_back('{mk_item(MODE_OBSERVE, 0, 0, 0, POS_MAX, 1, 1, 1, 1), 1'b0, '0});
      rows.push_back('{mk_item(MODE_CATCH_UP, 0, 0, 0, POS_MAX, 0, 0, 0, 0), 1'b0, '0});
      rows.push_back('{mk_item(MODE_DEACTIVATE, 0, 0, 0, 9100, 0, 0, 0, 0), 1'b1,
                       mk_res(1, ST_INACTIVE, 0, 0, 0, 0, 0, 0, 0)});
      rows.push_back('{mk_item(MODE_UNUSED_LO, 1, POS_MAX, 32'hFFFF_FFFF, POS_MAX,
                               1, 1, 1, 1), 1'b1, mk_res(0, ST_INACTIVE, 0, 0, 0, 0, 0, 0, 0)});
      rows.push_back('{mk_item(MODE_ACTIVATE, 0, 0, 0, 9200, 0, 0, 0, 0), 1'b1,
                       mk_res(1, ST_UNKNOWN, 0, 0, 0, 0, 0, 0, 0)});

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (rows[i]) send_event(rows[i].ev, rows[i].typed, rows[i].want);

      run_phase(120, 0, 0, 1'b1, DRIFT_TOL_RESET, SETTLE_RESET, COOLDOWN_RESET);
      run_phase(100, 57, 0, 1'b0, 16'd0, 16'd0, 16'd0);
      run_phase(100, 0, 57, 1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      run_phase(150, 33, 33, 1'b0, 16'($urandom_range(5000)), 16'($urandom_range(1000)),
                16'($urandom_range(6000)));
      run_phase(130, 0, 0, 1'b1, 16'd300, 16'hFFFF, 16'd0);

      req_valid <= 1'b0;
      for (wait_cycles = 0; wait_cycles < 5000 && pending_sync_results.size() != 0;
           wait_cycles++)
         @(posedge clock);
      repeat (10) @(posedge clock);
      if (pending_sync_results.size() != 0)
         report_failure($sformatf("%0d results never arrived", pending_sync_results.size()));
      if (mismatch_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   initial begin
      #(3_000_000);
      $display("CHECKS FAILED");
      $finish;
   end

endmodule
